FILE: src/sha_pkg.sv
// Package: SHA-256 constants, round functions and the shared request type.
package sha_pkg;

    localparam logic [31:0] ROUND_K [64] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    localparam logic [31:0] INIT_H [8] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    localparam int QUEUE_DEPTH = 4;
    localparam logic [7:0] PAD_BYTE = 8'h80;

    // Request from front to back: one byte and/or end mark.
    typedef struct packed {
        logic [7:0] data_byte;
        logic       has_byte;
        logic       message_end;
    } sha_req_t;

    function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
        rotr = (x >> n) | (x << (32 - n));
    endfunction

    function automatic logic [31:0] bsig0(input logic [31:0] x);
        bsig0 = rotr(x, 2) ^ rotr(x, 13) ^ rotr(x, 22);
    endfunction

    function automatic logic [31:0] bsig1(input logic [31:0] x);
        bsig1 = rotr(x, 6) ^ rotr(x, 11) ^ rotr(x, 25);
    endfunction

    function automatic logic [31:0] ssig0(input logic [31:0] x);
        ssig0 = rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
    endfunction

    function automatic logic [31:0] ssig1(input logic [31:0] x);
        ssig1 = rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
    endfunction

endpackage

FILE: src/sha256_message_hasher.sv
// Top level: SHA-256 hasher, byte stream in, 256-bit digest out.
//
// Slave stream: one request per message byte. tdata carries data_byte, tuser
// bit 0 is has_byte, tlast marks message_end. An end request with has_byte
// low ends the message without a byte (empty message allowed).
// Master stream: one 256-bit digest per message, digest_0 in tdata[63:0]
// through digest_3 in tdata[255:192], each big-endian.
// Requests go through a short queue into the hash engine. Each byte is
// shifted into the block buffer; every 64th byte starts a compression
// (load, 64 rounds, add) by the single round unit, during which no
// requests are taken. The end request starts padding: pad, zero and
// length bytes up to the end of the block (64 - n for n bytes held), plus
// a further padded block and compression when n >= 56, then the final
// compression and the digest into the output register.
// Reset loads the standard initial hash values and empties the queue.
// While the receiver stalls, the digest is held; the engine and queue keep
// taking bytes of the next message until its digest needs the output.
module sha256_message_hasher
    import sha_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH
)
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [7:0]   s_tdata,   // [7:0] data_byte
    input  logic         s_tuser,   // [0] has_byte
    input  logic         s_tlast,
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [255:0] m_tdata    // digest_0, digest_1, digest_2, digest_3
);

    sha_req_t     s_req, q_req;
    logic         q_valid, q_pop;
    logic [255:0] digest;

    assign s_req.data_byte   = s_tdata;
    assign s_req.has_byte    = s_tuser;
    assign s_req.message_end = s_tlast;

    sha_front #(.DEPTH(DEPTH)) u_front (
        .clk(clk), .rst_n(rst_n),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_req(s_req),
        .q_valid(q_valid), .q_pop(q_pop), .q_req(q_req)
    );

    sha_engine u_engine (
        .clk(clk), .rst_n(rst_n),
        .q_valid(q_valid), .q_pop(q_pop), .q_req(q_req),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(digest)
    );

    // Engine packs digest_0 high; port wants digest_0 low
    assign m_tdata = {digest[63:0], digest[127:64], digest[191:128], digest[255:192]};

endmodule

FILE: src/sha_front.sv
// Front end: input request queue feeding the hash engine.
module sha_front
    import sha_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  sha_req_t   s_req,
    output logic       q_valid,
    input  logic       q_pop,
    output sha_req_t   q_req
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    sha_req_t         mem_reg [DEPTH];
    logic [AW-1:0]    wr_ptr_reg, rd_ptr_reg;
    logic [AW:0]      count_reg;
    logic             push, pop;

    assign s_tready = (count_reg != (AW+1)'(DEPTH));
    assign q_valid  = (count_reg != '0);
    assign push     = s_tvalid && s_tready;
    assign pop      = q_pop && q_valid;
    assign q_req    = mem_reg[rd_ptr_reg];

    // Queue storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= s_req;
        end
    end

    // Pointers and count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == AW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == AW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            count_reg <= count_reg + (AW+1)'(push) - (AW+1)'(pop);
        end
    end

    assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= (AW+1)'(DEPTH))
        else $error("queue count overflow");
    assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg == '0) |-> !pop)
        else $error("pop from empty queue");
    assert property (@(posedge clk) disable iff (!rst_n)
        (push && !pop) |=> count_reg == $past(count_reg) + 1'b1)
        else $error("count not tracking push");

endmodule

FILE: src/sha_engine.sv
// Back end: block shift register, padding sequencer and one-round-per-cycle compressor.
module sha_engine
    import sha_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         q_valid,
    output logic         q_pop,
    input  sha_req_t     q_req,
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [255:0] m_tdata
);

    typedef enum logic [2:0] {
        ST_TAKE, ST_PAD, ST_LEN, ST_COMP, ST_ADD, ST_OUT
    } state_t;

    state_t        state_reg;
    logic [511:0]  blk_reg;        // block bytes, oldest byte in the top bits
    logic [5:0]    fill_reg;
    logic [63:0]   bits_reg;
    logic [63:0]   total_reg;      // bit length, shifted out a byte at a time
    logic [31:0]   h_reg [8];
    logic [31:0]   v_reg [8];
    logic [31:0]   w_reg [16];
    logic [5:0]    rnd_reg;
    logic          final_reg;      // compression in progress is the last one
    logic          pad_first_reg;  // pad byte still to be inserted
    logic          pad_active_reg; // padding sequence under way
    logic          len_reg;        // length bytes being inserted
    logic [255:0]  out_reg;
    logic          out_valid_reg;

    logic [31:0] t1, t2, w_new, w_cur;
    logic        len_byte;
    logic [7:0]  pad_byte;

    // Message schedule and round arithmetic
    always_comb
    begin
        w_cur = w_reg[0];
        w_new = ssig1(w_reg[14]) + w_reg[9] + ssig0(w_reg[1]) + w_reg[0];
        t1 = v_reg[7] + bsig1(v_reg[4]) + ((v_reg[4] & v_reg[5]) ^ (~v_reg[4] & v_reg[6]))
             + ROUND_K[rnd_reg] + w_cur;
        t2 = bsig0(v_reg[0]) + ((v_reg[0] & v_reg[1]) ^ (v_reg[0] & v_reg[2])
             ^ (v_reg[1] & v_reg[2]));
    end

    // Next padding byte: pad mark, zero fill or length byte
    always_comb
    begin
        len_byte = !pad_first_reg && (len_reg || fill_reg == 6'd56);
        if (pad_first_reg)
        begin
            pad_byte = PAD_BYTE;
        end
        else if (len_byte)
        begin
            pad_byte = total_reg[63:56];
        end
        else
        begin
            pad_byte = 8'd0;
        end
    end

    assign q_pop    = (state_reg == ST_TAKE) && q_valid;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_reg;

    // Sequencer, buffer and compression datapath
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_TAKE;
            blk_reg        <= '0;
            fill_reg       <= '0;
            bits_reg       <= '0;
            total_reg      <= '0;
            rnd_reg        <= '0;
            final_reg      <= 1'b0;
            pad_first_reg  <= 1'b0;
            pad_active_reg <= 1'b0;
            len_reg        <= 1'b0;
            out_valid_reg  <= 1'b0;
            for (int i = 0; i < 8; i++)
            begin
                h_reg[i] <= INIT_H[i];
            end
        end
        else
        begin
            if (out_valid_reg && m_tready && state_reg != ST_OUT)
            begin
                out_valid_reg <= 1'b0;
            end
            case (state_reg)
                ST_TAKE:
                begin
                    if (q_pop)
                    begin
                        if (q_req.has_byte)
                        begin
                            blk_reg  <= {blk_reg[503:0], q_req.data_byte};
                            fill_reg <= fill_reg + 1'b1;
                        end
                        if (q_req.message_end)
                        begin
                            pad_first_reg <= 1'b1;
                        end
                        if (q_req.has_byte && fill_reg == 6'd63)
                        begin
                            // full block: compress before any padding
                            final_reg <= 1'b0;
                            bits_reg  <= bits_reg + 64'd512;
                            state_reg <= ST_LEN;
                        end
                        else if (q_req.message_end)
                        begin
                            state_reg <= ST_PAD;
                        end
                    end
                end
                ST_PAD:
                begin
                    // one padding byte per cycle up to the end of the block
                    blk_reg        <= {blk_reg[503:0], pad_byte};
                    fill_reg       <= fill_reg + 1'b1;
                    pad_active_reg <= 1'b1;
                    if (pad_first_reg)
                    begin
                        total_reg     <= bits_reg + {55'd0, fill_reg, 3'd0};
                        pad_first_reg <= 1'b0;
                    end
                    else if (len_byte)
                    begin
                        total_reg <= {total_reg[55:0], 8'd0};
                        len_reg   <= 1'b1;
                    end
                    if (fill_reg == 6'd63)
                    begin
                        final_reg <= len_byte;
                        state_reg <= ST_LEN;
                    end
                end
                ST_LEN:
                begin
                    state_reg <= ST_COMP;
                    rnd_reg   <= '0;
                    for (int i = 0; i < 16; i++)
                    begin
                        w_reg[i] <= blk_reg[511 - 32*i -: 32];
                    end
                    for (int i = 0; i < 8; i++)
                    begin
                        v_reg[i] <= h_reg[i];
                    end
                end
                ST_COMP:
                begin
                    for (int i = 0; i < 15; i++)
                    begin
                        w_reg[i] <= w_reg[i+1];
                    end
                    w_reg[15] <= w_new;
                    v_reg[7] <= v_reg[6];
                    v_reg[6] <= v_reg[5];
                    v_reg[5] <= v_reg[4];
                    v_reg[4] <= v_reg[3] + t1;
                    v_reg[3] <= v_reg[2];
                    v_reg[2] <= v_reg[1];
                    v_reg[1] <= v_reg[0];
                    v_reg[0] <= t1 + t2;
                    rnd_reg  <= rnd_reg + 1'b1;
                    if (rnd_reg == 6'd63)
                    begin
                        state_reg <= ST_ADD;
                    end
                end
                ST_ADD:
                begin
                    for (int i = 0; i < 8; i++)
                    begin
                        h_reg[i] <= h_reg[i] + v_reg[i];
                    end
                    if (final_reg)
                    begin
                        state_reg <= ST_OUT;
                    end
                    else if (pad_first_reg || pad_active_reg)
                    begin
                        state_reg <= ST_PAD;
                    end
                    else
                    begin
                        state_reg <= ST_TAKE;
                    end
                end
                ST_OUT:
                begin
                    if (!out_valid_reg || m_tready)
                    begin
                        for (int i = 0; i < 8; i++)
                        begin
                            out_reg[255 - 32*i -: 32] <= h_reg[i];
                            h_reg[i] <= INIT_H[i];
                        end
                        out_valid_reg  <= 1'b1;
                        fill_reg       <= '0;
                        bits_reg       <= '0;
                        final_reg      <= 1'b0;
                        pad_active_reg <= 1'b0;
                        len_reg        <= 1'b0;
                        state_reg      <= ST_TAKE;
                    end
                end
                default:
                begin
                    state_reg <= ST_TAKE;
                end
            endcase
        end
    end

    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_COMP && rnd_reg == 6'd63) |=> state_reg == ST_ADD)
        else $error("compression did not finish after 64 rounds");
    assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> state_reg == ST_TAKE)
        else $error("request taken while busy");
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !m_tready) |=> $stable(out_reg))
        else $error("digest changed while stalled");
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !m_tready) |=> out_valid_reg)
        else $error("digest dropped while stalled");

endmodule
